>>> hw/rtl/ufs_pkg.sv
`timescale 1ns / 1ps

package ufs_pkg;

  localparam int ELEMENTS   = 1024;
  localparam int ELEM_W     = 10;
  localparam int ADDR_W     = (ELEMENTS > 2) ? $clog2(ELEMENTS) : 1;
  localparam int WALK_LIMIT = 2 * ELEMENTS + 4;
  localparam int STEP_W     = $clog2(WALK_LIMIT + 1);

  localparam logic OP_UNION = 1'b0;
  localparam logic OP_FIND  = 1'b1;

  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic  idle;
    logic  done;
    elem_t root;
    logic  merged;
  } ctrl_status_t;

  function automatic logic in_range(elem_t x);
    return 32'(x) < 32'(ELEMENTS);
  endfunction

  function automatic addr_t to_addr(elem_t x);
    return ADDR_W'(x);
  endfunction

endpackage

>>> hw/rtl/ufs_ram.sv
`timescale 1ns / 1ps

module ufs_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr0,
  input  logic [$clog2(DEPTH)-1:0] rd_addr1,
  output logic [WIDTH-1:0]         rd_data0,
  output logic [WIDTH-1:0]         rd_data1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data0 <= mem[rd_addr0];
    rd_data1 <= mem[rd_addr1];
  end

endmodule

>>> hw/rtl/ufs_ctrl.sv
`timescale 1ns / 1ps

module ufs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  opcode,
  input  ufs_pkg::elem_t        elem_a,
  input  ufs_pkg::elem_t        elem_b,
  input  logic                  out_free,
  input  ufs_pkg::elem_t        rd_data0,
  input  ufs_pkg::elem_t        rd_data1,
  output ufs_pkg::addr_t        rd_addr0,
  output ufs_pkg::addr_t        rd_addr1,
  output logic                  wr_en,
  output ufs_pkg::addr_t        wr_addr,
  output ufs_pkg::elem_t        wr_data,
  output ufs_pkg::ctrl_status_t status
);

  import ufs_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FIND_UP,
    S_FIND_FIX,
    S_UNION,
    S_OUT
  } state_t;

  state_t              state;
  addr_t               clr_cnt;
  logic [STEP_W-1:0]   steps;
  elem_t               x;
  elem_t               y;
  elem_t               res;
  logic                link_made;

  logic step_max;
  logic eq0;
  logic lt01;
  logic eq01;
  logic walk_go;

  // Shared compare on the words coming back from the table.
  assign step_max = (steps == STEP_W'(WALK_LIMIT));
  assign eq0      = (rd_data0 == x);
  assign eq01     = (rd_data0 == rd_data1);
  assign lt01     = (rd_data0 < rd_data1);

  always_comb begin
    walk_go  = 1'b0;
    rd_addr0 = to_addr(x);
    rd_addr1 = to_addr(y);
    wr_en    = 1'b0;
    wr_addr  = to_addr(x);
    wr_data  = y;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        wr_data = ELEM_W'(clr_cnt);
      end
      S_IDLE: begin
        rd_addr0 = to_addr(elem_a);
        rd_addr1 = to_addr(elem_b);
      end
      S_FIND_UP: begin
        walk_go = !eq0 && !step_max;
        if (walk_go) begin
          rd_addr0 = to_addr(rd_data0);
        end else begin
          rd_addr0 = to_addr(y);
        end
      end
      S_FIND_FIX: begin
        walk_go = !eq0 && !step_max;
        if (walk_go) begin
          wr_en    = 1'b1;
          wr_addr  = to_addr(y);
          wr_data  = x;
          rd_addr0 = to_addr(rd_data0);
        end
      end
      S_UNION: begin
        walk_go = !eq01 && !step_max;
        if (walk_go) begin
          wr_en = 1'b1;
          if (lt01) begin
            wr_addr  = to_addr(x);
            wr_data  = rd_data1;
            rd_addr0 = to_addr(rd_data0);
          end else begin
            wr_addr  = to_addr(y);
            wr_data  = rd_data0;
            rd_addr1 = to_addr(rd_data1);
          end
        end
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      steps     <= '0;
      link_made <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == ADDR_W'(ELEMENTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            steps     <= '0;
            link_made <= 1'b0;
            x         <= elem_a;
            if (opcode == OP_FIND) begin
              res   <= elem_a;
              y     <= elem_a;
              state <= in_range(elem_a) ? S_FIND_UP : S_OUT;
            end else begin
              res   <= elem_b;
              y     <= elem_b;
              state <= (in_range(elem_a) && in_range(elem_b)) ? S_UNION : S_OUT;
            end
          end
        end
        S_FIND_UP: begin
          if (walk_go) begin
            x     <= rd_data0;
            steps <= steps + 1'b1;
          end else begin
            steps <= '0;
            state <= S_FIND_FIX;
          end
        end
        S_FIND_FIX: begin
          if (walk_go) begin
            y     <= rd_data0;
            steps <= steps + 1'b1;
          end else begin
            res   <= x;
            state <= S_OUT;
          end
        end
        S_UNION: begin
          if (!walk_go) begin
            state <= S_OUT;
          end else begin
            steps <= steps + 1'b1;
            if (lt01) begin
              if (rd_data0 == x) begin
                res       <= rd_data1;
                link_made <= 1'b1;
                state     <= S_OUT;
              end else begin
                x <= rd_data0;
              end
            end else begin
              if (rd_data1 == y) begin
                res       <= rd_data0;
                link_made <= 1'b1;
                state     <= S_OUT;
              end else begin
                y <= rd_data1;
              end
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign status.idle   = (state == S_IDLE);
  assign status.done   = (state == S_OUT);
  assign status.root   = res;
  assign status.merged = link_made;

endmodule

>>> hw/rtl/union_find_splice_engine.sv
// Find walks up to the root, then makes a second pass that points each node on the path
// at the root; union splices until one step links or both sides turn out already joined.
// Throughput: one transaction at a time; in_ready returns in the same cycle that the result
// is registered, and a result waiting on out_ready holds the next one before output.
// Reset: synchronous; afterwards a clearing pass sets every table entry to its
// own index while in_ready stays low.
`timescale 1ns / 1ps

module union_find_splice_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           opcode,
  input  ufs_pkg::elem_t elem_a,
  input  ufs_pkg::elem_t elem_b,
  output logic           out_valid,
  input  logic           out_ready,
  output ufs_pkg::elem_t result_root,
  output logic           merged
);

  import ufs_pkg::*;

  ctrl_status_t status;
  addr_t        rd_addr0;
  addr_t        rd_addr1;
  addr_t        wr_addr;
  elem_t        rd_data0;
  elem_t        rd_data1;
  elem_t        wr_data;
  logic         wr_en;
  logic         start;
  logic         out_free;

  assign in_ready = status.idle;
  assign start    = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  ufs_ram #(
    .WIDTH(ELEM_W),
    .DEPTH(ELEMENTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr0(rd_addr0),
    .rd_addr1(rd_addr1),
    .rd_data0(rd_data0),
    .rd_data1(rd_data1)
  );

  ufs_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .opcode  (opcode),
    .elem_a  (elem_a),
    .elem_b  (elem_b),
    .out_free(out_free),
    .rd_data0(rd_data0),
    .rd_data1(rd_data1),
    .rd_addr0(rd_addr0),
    .rd_addr1(rd_addr1),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .status  (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (status.done && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.done && out_free) begin
      result_root <= status.root;
      merged      <= status.merged;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready stayed high after a transaction was accepted");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("in_ready high right after reset, before the clearing pass");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (status.done && out_free) |=> out_valid)
    else $error("finished transaction did not reach the output register");

  a_no_double_result: assert property (@(posedge clk) disable iff (rst)
    (status.done && out_free) |=> !status.done)
    else $error("result delivered twice for one transaction");
`endif

endmodule
